// File: rtl/oets_pkg.sv
`default_nettype none

package oets_pkg;

  localparam int KEY_W = 32;
  localparam int DEPTH_DEFAULT = 16;

  typedef logic signed [KEY_W-1:0] key_t;

  // commands broadcast to every cell of the row
  typedef struct packed {
    logic load;       // a key is written into the selected cell
    logic sort;       // one transposition phase this cycle
    logic odd_phase;  // 0: pairs (0,1),(2,3).. 1: pairs (1,2),(3,4)..
    logic shift;      // every cell but the last takes its right neighbor's key
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/odd_even_transposition_sorter.sv
`default_nettype none

// odd-even transposition sorter: signed 32-bit keys are loaded one per input
// transaction into a row of DEPTH cells. a set ends on a key with final_key
// set, or when the row is full (the DEPTH-th key then counts as last). the
// set of n keys is sorted in place by n transposition phases, one per clock,
// each cell comparing with its neighbor and swapping only on strictly
// greater. the keys then leave in ascending order, one per output
// transaction, with final_out on the last one, by shifting the row toward
// cell 0. a set is loaded, sorted and drained in turn; the sort phases are
// bounded by the one compare-and-swap per cell per clock. one set is handled
// at a time: no input transaction is taken while a set is sorted or drained.
module odd_even_transposition_sorter #(
  parameter int DEPTH = oets_pkg::DEPTH_DEFAULT
) (
  input  wire             logic clk,
  input  wire             logic rst,
  input  wire             logic in_valid,
  output                  logic in_ready,
  input  wire  oets_pkg::key_t key,
  input  wire             logic final_key,
  output                  logic out_valid,
  input  wire             logic out_ready,
  output       oets_pkg::key_t sorted_key,
  output                  logic final_out
);
  import oets_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // controller states
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SORT  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;  // keys loaded, then keys left to drain
  logic [CNT_W-1:0] phase, phase_next;
  logic             odd_phase, odd_phase_next;

  logic in_xfer;
  logic out_xfer;
  logic set_done;

  cell_ctrl_t ctrl;

  key_t cell_key [DEPTH];

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_DRAIN);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // the row is full once the key at the last cell goes in
  assign set_done = final_key || (count == CNT_W'(DEPTH - 1));

  assign sorted_key = cell_key[0];
  assign final_out  = (count == CNT_W'(1));

  assign ctrl.load      = in_xfer;
  assign ctrl.sort      = (state == ST_SORT);
  assign ctrl.odd_phase = odd_phase;
  assign ctrl.shift     = out_xfer;

  always_comb begin
    state_next     = state;
    count_next     = count;
    phase_next     = phase;
    odd_phase_next = odd_phase;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer) begin
          count_next = count + CNT_W'(1);
          if (set_done) begin
            state_next     = ST_SORT;
            phase_next     = '0;
            odd_phase_next = 1'b0;
          end
        end
      end
      ST_SORT: begin
        // n phases for n keys, alternating even and odd pairs
        phase_next     = phase + CNT_W'(1);
        odd_phase_next = ~odd_phase;
        if (phase == count - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      phase     <= '0;
      odd_phase <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      phase     <= phase_next;
      odd_phase <= odd_phase_next;
    end
  end

  // row of cells; cell i holds the i-th key of the set
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic sel;
    logic active;
    logic right_active;
    key_t left_key;
    key_t right_key;

    // during load count is the write slot, during sort it is the set size
    assign sel          = (count == CNT_W'(i));
    assign active       = (CNT_W'(i) < count);
    assign right_active = (CNT_W'(i + 1) < count);

    if (i == 0) begin : g_first
      assign left_key = cell_key[i];
    end else begin : g_mid
      assign left_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    oets_cell #(
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .sel          (sel),
      .active       (active),
      .right_active (right_active),
      .load_key     (key),
      .left_key     (left_key),
      .right_key    (right_key),
      .key_q        (cell_key[i])
    );
  end

endmodule

`default_nettype wire

// File: rtl/oets_cell.sv
`default_nettype none

module oets_cell #(
  parameter int INDEX = 0
) (
  input  wire                logic clk,
  input  wire  oets_pkg::cell_ctrl_t ctrl,
  input  wire                logic sel,
  input  wire                logic active,
  input  wire                logic right_active,
  input  wire  oets_pkg::key_t load_key,
  input  wire  oets_pkg::key_t left_key,
  input  wire  oets_pkg::key_t right_key,
  output       oets_pkg::key_t key_q
);
  import oets_pkg::*;

  localparam logic IS_ODD   = (INDEX % 2) == 1;
  localparam logic HAS_LEFT = INDEX > 0;

  key_t key_next;
  logic left_of_pair;
  logic right_of_pair;

  assign left_of_pair  = (IS_ODD == ctrl.odd_phase) && right_active;
  assign right_of_pair = (IS_ODD != ctrl.odd_phase) && active && HAS_LEFT;

  always_comb begin
    key_next = key_q;
    if (ctrl.shift) begin
      key_next = right_key;
    end else if (ctrl.load && sel) begin
      key_next = load_key;
    end else if (ctrl.sort) begin
      // swap only on strictly greater, so equal keys stay put
      if (left_of_pair && (key_q > right_key)) begin
        key_next = right_key;
      end else if (right_of_pair && (left_key > key_q)) begin
        key_next = left_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

`default_nettype wire
